// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// label: antecedent implies consequent on the same edge
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// label: antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/lgft_pkg.sv =====
// ----------------------------------------------------------------------------
// lgft_pkg
// Types, codes and helpers for the fading-trail life grid.
// ----------------------------------------------------------------------------
package lgft_pkg;
	localparam int GRID_WIDTH_DEF  = 64;
	localparam int GRID_HEIGHT_DEF = 64;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_GEN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [2:0] CFG_ALIVE_COLOR  = 3'd0;
	localparam logic [2:0] CFG_FADE_ENABLED = 3'd1;
	localparam logic [2:0] CFG_DYING_DROP   = 3'd2;
	localparam logic [2:0] CFG_FADE_DROP    = 3'd3;
	localparam logic [2:0] CFG_TRAIL_LENGTH = 3'd4;

	localparam logic [2:0] STATE_ALIVE = 3'd4;

	typedef struct packed {
		logic [23:0] alive_color;
		logic        fade_enabled;
		logic [7:0]  dying_drop;
		logic [7:0]  fade_drop;
		logic [1:0]  trail_length;
	} cfg_t;

	function automatic logic [23:0] sub_channels(input logic [23:0] color,
		input logic [7:0] drop);
		logic [23:0] r;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			r[k*8 +: 8] = (color[k*8 +: 8] > drop) ? color[k*8 +: 8] - drop : 8'd0;
		end
		return r;
	endfunction
endpackage

// ===== hdl/lgft_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lgft_cfg_regs
// Configuration register file.
// ----------------------------------------------------------------------------
module lgft_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	output lgft_pkg::cfg_t      cfg
);
	lgft_pkg::cfg_t cfg_q;
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alive_color  <= 24'hFFFFFF;
			cfg_q.fade_enabled <= 1'b0;
			cfg_q.dying_drop   <= 8'd180;
			cfg_q.fade_drop    <= 8'd25;
			cfg_q.trail_length <= 2'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lgft_pkg::CFG_ALIVE_COLOR:  cfg_q.alive_color  <= cfg_data;
				lgft_pkg::CFG_FADE_ENABLED: cfg_q.fade_enabled <= cfg_data[0];
				lgft_pkg::CFG_DYING_DROP:   cfg_q.dying_drop   <= cfg_data[7:0];
				lgft_pkg::CFG_FADE_DROP:    cfg_q.fade_drop    <= cfg_data[7:0];
				lgft_pkg::CFG_TRAIL_LENGTH: cfg_q.trail_length <= cfg_data[1:0];
				default: ;
			endcase
		end
	end
endmodule

// ===== hdl/lgft_engine.sv =====
// ----------------------------------------------------------------------------
// lgft_engine
// Sequencer over the state, colour and next-state memories: clear, write, read, generation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lgft_engine #(
	parameter int GRID_WIDTH  = lgft_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lgft_pkg::GRID_HEIGHT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lgft_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     opcode,
	input  logic [5:0]     col,
	input  logic [5:0]     row,
	input  logic [2:0]     new_state,
	input  logic [23:0]    new_color,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [23:0]    cell_color,
	output logic [2:0]     cell_state
);
	localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW = $clog2(CELLS);
	localparam int XW = $clog2(GRID_WIDTH);
	localparam int YW = $clog2(GRID_HEIGHT);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_RDW   = 4'd3;
	localparam logic [3:0] ST_GNB   = 4'd4;
	localparam logic [3:0] ST_GNBW  = 4'd5;
	localparam logic [3:0] ST_GCEN  = 4'd6;
	localparam logic [3:0] ST_GCENW = 4'd7;
	localparam logic [3:0] ST_GCOPY = 4'd8;
	localparam logic [3:0] ST_GCPW  = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	localparam logic [1:0] DIR_MINUS = 2'd0;
	localparam logic [1:0] DIR_SAME  = 2'd1;
	localparam logic [1:0] DIR_PLUS  = 2'd2;

	logic [2:0]  st_mem [CELLS];
	logic [23:0] col_mem [CELLS];
	logic [2:0]  nx_mem [CELLS];

	logic [3:0]    state_q;
	logic [AW:0]   clr_q;
	logic [AW-1:0] addr_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [3:0]    nb_q;
	logic [3:0]    live_q;
	logic [23:0]   ocol_q;
	logic [2:0]    ost_q;

	logic          st_we, col_we, nx_we;
	logic [AW-1:0] st_wa, col_wa, nx_wa, st_ra, nx_ra;
	logic [2:0]    st_wd, nx_wd;
	logic [23:0]   col_wd;
	logic [2:0]    st_rd, nx_rd;
	logic [23:0]   col_rd;

	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_wa] <= st_wd;
		if (col_we) col_mem[col_wa] <= col_wd;
		if (nx_we) nx_mem[nx_wa] <= nx_wd;
		st_rd  <= st_mem[st_ra];
		col_rd <= col_mem[st_ra];
		nx_rd  <= nx_mem[nx_ra];
	end

	logic [XW:0] cm;
	logic [YW:0] rm;
	logic [AW-1:0] in_addr;
	always_comb begin
		cm = (XW+1)'(col);
		rm = (YW+1)'(row);
		for (int k = 0; k < 6; k++) begin
			if (cm >= (XW+1)'(GRID_WIDTH)) cm = cm - (XW+1)'(GRID_WIDTH);
			if (rm >= (YW+1)'(GRID_HEIGHT)) rm = rm - (YW+1)'(GRID_HEIGHT);
		end
		in_addr = AW'(rm[YW-1:0] * GRID_WIDTH + cm[XW-1:0]);
	end

	// neighbor nb_q: 0..2 row above, 3..4 same row, 5..7 row below
	logic [XW-1:0] nbx;
	logic [YW-1:0] nby;
	logic [1:0]    dxs, dys;
	always_comb begin
		dxs = DIR_SAME;
		dys = DIR_SAME;
		unique case (nb_q)
			4'd0: begin dxs = DIR_MINUS; dys = DIR_MINUS; end
			4'd1: begin dxs = DIR_SAME;  dys = DIR_MINUS; end
			4'd2: begin dxs = DIR_PLUS;  dys = DIR_MINUS; end
			4'd3: begin dxs = DIR_MINUS; dys = DIR_SAME;  end
			4'd4: begin dxs = DIR_PLUS;  dys = DIR_SAME;  end
			4'd5: begin dxs = DIR_MINUS; dys = DIR_PLUS;  end
			4'd6: begin dxs = DIR_SAME;  dys = DIR_PLUS;  end
			4'd7: begin dxs = DIR_PLUS;  dys = DIR_PLUS;  end
			default: ;
		endcase
		unique case (dxs)
			DIR_MINUS: nbx = (x_q == '0) ? XW'(GRID_WIDTH - 1) : x_q - XW'(1);
			DIR_PLUS:  nbx = (x_q == XW'(GRID_WIDTH - 1)) ? '0 : x_q + XW'(1);
			default:   nbx = x_q;
		endcase
		unique case (dys)
			DIR_MINUS: nby = (y_q == '0) ? YW'(GRID_HEIGHT - 1) : y_q - YW'(1);
			DIR_PLUS:  nby = (y_q == YW'(GRID_HEIGHT - 1)) ? '0 : y_q + YW'(1);
			default:   nby = y_q;
		endcase
	end

	logic in_fire;
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_valid  = (state_q == ST_OUT);
	assign cell_color = ocol_q;
	assign cell_state = ost_q;

	logic dies;
	logic [2:0] rd_state;
	always_comb begin
		st_we = 1'b0; col_we = 1'b0; nx_we = 1'b0;
		st_wa = addr_q; col_wa = addr_q; nx_wa = addr_q;
		st_wd = '0; col_wd = '0; nx_wd = '0;
		st_ra = AW'(nby * GRID_WIDTH + nbx);
		nx_ra = addr_q;
		dies = (live_q != 4'd2) && (live_q != 4'd3);
		rd_state = st_rd;
		unique case (state_q)
			ST_CLEAR: begin
				st_we = 1'b1; col_we = 1'b1;
				st_wa = clr_q[AW-1:0]; col_wa = clr_q[AW-1:0];
			end
			ST_IDLE: begin
				st_ra = in_addr;
				if (in_fire && opcode == lgft_pkg::OP_WRITE) begin
					st_we = 1'b1; col_we = 1'b1;
					st_wa = in_addr; col_wa = in_addr;
					st_wd = (new_state > lgft_pkg::STATE_ALIVE) ? lgft_pkg::STATE_ALIVE
						: new_state;
					col_wd = new_color;
				end
			end
			ST_RD: st_ra = addr_q;
			ST_RDW: begin
				if (st_rd == lgft_pkg::STATE_ALIVE) begin
					col_we = 1'b1; col_wd = cfg.alive_color;
				end else if (st_rd != 3'd0 && cfg.fade_enabled) begin
					col_we = 1'b1; st_we = 1'b1;
					col_wd = lgft_pkg::sub_channels(col_rd, cfg.fade_drop);
					rd_state = st_rd - 3'd1;
					st_wd = rd_state;
				end
			end
			ST_GCEN: st_ra = addr_q;
			ST_GCENW: begin
				nx_we = 1'b1;
				if (st_rd == lgft_pkg::STATE_ALIVE) begin
					if (dies) begin
						nx_wd = {1'b0, cfg.trail_length};
						col_we = 1'b1;
						col_wd = lgft_pkg::sub_channels(col_rd, cfg.dying_drop);
					end else nx_wd = lgft_pkg::STATE_ALIVE;
				end else nx_wd = (live_q == 4'd3) ? lgft_pkg::STATE_ALIVE : st_rd;
			end
			ST_GCPW: begin
				st_we = 1'b1; st_wd = nx_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			addr_q  <= '0;
			x_q <= '0; y_q <= '0; nb_q <= '0; live_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(CELLS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_fire) begin
					addr_q <= in_addr;
					x_q <= '0; y_q <= '0; nb_q <= '0; live_q <= '0;
					if (opcode == lgft_pkg::OP_READ) state_q <= ST_RD;
					else if (opcode == lgft_pkg::OP_GEN) begin
						addr_q <= '0;
						state_q <= ST_GNB;
					end
				end
				ST_RD: state_q <= ST_RDW;
				ST_RDW: state_q <= ST_OUT;
				ST_GNB: begin
					nb_q <= 4'd1;
					state_q <= ST_GNBW;
				end
				// st_rd holds neighbor nb_q-1 here
				ST_GNBW: begin
					if (st_rd == lgft_pkg::STATE_ALIVE) live_q <= live_q + 4'd1;
					nb_q <= nb_q + 4'd1;
					state_q <= (nb_q == 4'd8) ? ST_GCEN : ST_GNBW;
				end
				ST_GCEN: state_q <= ST_GCENW;
				ST_GCENW: begin
					nb_q <= '0; live_q <= '0;
					if (addr_q == AW'(CELLS - 1)) begin
						addr_q <= '0;
						state_q <= ST_GCOPY;
					end else begin
						addr_q <= addr_q + 1'b1;
						state_q <= ST_GNB;
						if (x_q == XW'(GRID_WIDTH - 1)) begin
							x_q <= '0; y_q <= y_q + 1'b1;
						end else x_q <= x_q + 1'b1;
					end
				end
				ST_GCOPY: state_q <= ST_GCPW;
				ST_GCPW: begin
					if (addr_q == AW'(CELLS - 1)) state_q <= ST_IDLE;
					else begin
						addr_q <= addr_q + 1'b1;
						state_q <= ST_GCOPY;
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RDW) begin
			ost_q  <= rd_state;
			ocol_q <= col_we ? col_wd : col_rd;
		end
	end

	`ASSERT_IMPL(a_out_only_idle_next, clk, arst_n, out_valid, !in_ready, "accept during output")
	`ASSERT_NEXT(a_rdw_to_out, clk, arst_n, state_q == ST_RDW, out_valid, "read lost")
	`ASSERT_IMPL(a_live_range, clk, arst_n, state_q == ST_GCENW, live_q <= 4'd8,
		"neighbor count overflow")
endmodule

// ===== hdl/life_grid_with_fading_trail_top.sv =====
// ----------------------------------------------------------------------------
// life_grid_with_fading_trail_top
// Toroidal life grid with fading trails held in on-chip memories.
// ----------------------------------------------------------------------------
// Channels: input items (opcode, col, row, new_state, new_color) on
// in_valid/in_ready; read results (cell_color, cell_state) on
// out_valid/out_ready; register writes on cfg_valid/cfg_ready, always ready.
// A write item is stored as it is accepted. A read passes ST_RD and ST_RDW;
// the result then sits in an output register until the receiver takes it,
// and no new item is accepted meanwhile. A generation scans the neighbors of
// each cell (one memory read port, one neighbor per cycle), reads the cell,
// writes its next state, and then copies all next states back.
// After reset a clearing pass over all W*H cells zeroes states and colors;
// no item is accepted until it ends, register writes are taken throughout.
// ----------------------------------------------------------------------------
module life_grid_with_fading_trail_top #(
	parameter int GRID_WIDTH  = lgft_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lgft_pkg::GRID_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [5:0]  col,
	input  logic [5:0]  row,
	input  logic [2:0]  new_state,
	input  logic [23:0] new_color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] cell_color,
	output logic [2:0]  cell_state
);
	lgft_pkg::cfg_t cfg;

	lgft_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
	);

	lgft_engine #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_eng (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .col(col),
		.row(row), .new_state(new_state), .new_color(new_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_color(cell_color), .cell_state(cell_state)
	);
endmodule
